// ===== src/assert_macros.svh =====
// assert_macros.svh: concurrent assertion helpers shared by the RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check expr at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// check that cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ftea_pkg.sv =====
// ftea_pkg: widths, codes, constants and the result type of the FAT entry access unit.
// Depends on nothing; used by the interfaces, the RAM and the top level.
`default_nettype none

package ftea_pkg;

   localparam int TABLE_BYTES_DEF = 16384;
   localparam int BYTE_W          = 8;
   localparam int LANES           = 4;
   localparam int LANE_W          = 2;
   localparam int CLUSTER_W       = 14;
   localparam int VALUE_W         = 28;
   localparam int STATUS_W        = 3;
   localparam int NKIND_W         = 2;
   localparam int TKIND_W         = 2;
   localparam int OFF_W           = 17;
   localparam int SPAN_SHORT      = 2;
   localparam int SPAN_LONG       = 4;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int RQ_DEPTH        = 3;
   localparam int RQ_PTR_W        = 2;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [NKIND_W-1:0] NK_LITERAL = 2'd0;
   localparam logic [NKIND_W-1:0] NK_EOC     = 2'd1;
   localparam logic [NKIND_W-1:0] NK_BAD     = 2'd2;
   localparam logic [NKIND_W-1:0] NK_NONE    = 2'd3;

   localparam logic [TKIND_W-1:0] TK_FAT12 = 2'd0;
   localparam logic [TKIND_W-1:0] TK_FAT16 = 2'd1;
   localparam logic [TKIND_W-1:0] TK_FAT32 = 2'd2;

   localparam logic [STATUS_W-1:0] ST_NEXT = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FREE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EOC  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ERR  = 3'd4;

   localparam logic REG_TABLE_KIND   = 1'b0;
   localparam logic REG_LAST_CLUSTER = 1'b1;

   localparam logic [TKIND_W-1:0]   TABLE_KIND_RST   = TK_FAT12;
   localparam logic [CLUSTER_W-1:0] LAST_CLUSTER_RST = 14'h3FFF;

   localparam logic [VALUE_W-1:0] MASK12   = 28'h0000FFF;
   localparam logic [VALUE_W-1:0] MASK16   = 28'h000FFFF;
   localparam logic [VALUE_W-1:0] MASK28   = 28'hFFFFFFF;
   localparam logic [VALUE_W-1:0] EOC_MARK = 28'hFFFFFF8;
   localparam logic [VALUE_W-1:0] BAD_MARK = 28'hFFFFFF7;

   localparam logic [BYTE_W-1:0] NIB_HI = 8'hF0;
   localparam logic [BYTE_W-1:0] NIB_LO = 8'h0F;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
   } result_type;

endpackage

`default_nettype wire

// ===== src/ftea_if.sv =====
// ftea_if: valid/ready channel interfaces for access requests and results.
// Depends on ftea_pkg for field widths.
`default_nettype none

interface ftea_req_if;
   logic                              valid;
   logic                              ready;
   logic                              opcode;
   logic [ftea_pkg::CLUSTER_W-1:0]    cluster;
   logic [ftea_pkg::VALUE_W-1:0]      next_value;
   logic [ftea_pkg::NKIND_W-1:0]      next_kind;

   modport source (output valid, opcode, cluster, next_value, next_kind, input ready);
   modport sink   (input valid, opcode, cluster, next_value, next_kind, output ready);
endinterface

interface ftea_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ftea_pkg::STATUS_W-1:0]     status;
   logic [ftea_pkg::VALUE_W-1:0]      value;

   modport source (output valid, status, value, input ready);
   modport sink   (input valid, status, value, output ready);
endinterface

`default_nettype wire

// ===== src/ftea_ram.sv =====
// ftea_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on ftea_pkg for default sizes.
`default_nettype none

module ftea_ram #(
   parameter int WIDTH = ftea_pkg::BYTE_W,
   parameter int DEPTH = ftea_pkg::TABLE_BYTES_DEF / ftea_pkg::LANES,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/fat_table_entry_access_unit.sv =====
// fat_table_entry_access_unit: FAT12/16/32 allocation table entry read and write.
// Depends on ftea_pkg, ftea_if, ftea_ram and assert_macros.svh.
//
// channel   dir  handshake             payload
// req_chan  in   valid/ready           opcode, cluster, next_value, next_kind
// rsp_chan  out  valid/ready           status, value
// csr_*     in   APB psel/penable      table_kind at 0x0, last_cluster at 0x4
//
// An item enters every cycle while req_chan.ready is high; its result passes the stage 1
// registers into the result queue, from which it leaves when rsp_chan.ready allows.
// The entry bytes sit in four byte-lane RAMs, read on acceptance and written back the
// next cycle; a write followed at once by a read of the same row is forwarded.
// After reset a clearing pass writes TABLE_BYTES/4 rows (4096 rows by default)
// with req_chan.ready low; CSR writes are taken throughout.
// A three-entry result queue absorbs rsp_chan stalls; req_chan.ready drops when queued plus in-flight results fill it.
`default_nettype none

module fat_table_entry_access_unit #(
   parameter int TABLE_BYTES = ftea_pkg::TABLE_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   ftea_req_if.sink                           req_chan,
   ftea_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ftea_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ftea_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ftea_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

`include "assert_macros.svh"

   localparam int ROWS   = TABLE_BYTES / ftea_pkg::LANES;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LANES  = ftea_pkg::LANES;
   localparam int LANE_W = ftea_pkg::LANE_W;
   localparam int BW     = ftea_pkg::BYTE_W;
   localparam int VW     = ftea_pkg::VALUE_W;
   localparam int CW     = ftea_pkg::CLUSTER_W;
   localparam int OW     = ftea_pkg::OFF_W;

   // configuration
   logic [ftea_pkg::TKIND_W-1:0] table_kind_ff;
   logic [CW-1:0]                last_cluster_ff;
   logic                         csr_wr;
   logic                         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         table_kind_ff   <= ftea_pkg::TABLE_KIND_RST;
         last_cluster_ff <= ftea_pkg::LAST_CLUSTER_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            ftea_pkg::REG_TABLE_KIND: begin
               table_kind_ff <= csr_pwdata[ftea_pkg::TKIND_W-1:0];
            end
            ftea_pkg::REG_LAST_CLUSTER: begin
               last_cluster_ff <= csr_pwdata[CW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         ftea_pkg::REG_TABLE_KIND:   csr_prdata = ftea_pkg::CSR_DATA_W'(table_kind_ff);
         ftea_pkg::REG_LAST_CLUSTER: csr_prdata = ftea_pkg::CSR_DATA_W'(last_cluster_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // control state
   logic                          clear_ff;
   logic [ROW_W-1:0]              clear_row_ff;
   logic                          s1_valid_ff;
   logic [ftea_pkg::RQ_PTR_W-1:0] wr_ptr_ff;
   logic [ftea_pkg::RQ_PTR_W-1:0] rd_ptr_ff;
   logic [ftea_pkg::RQ_PTR_W-1:0] cnt_ff;
   logic [ftea_pkg::RQ_PTR_W-1:0] wr_ptr_in;
   logic [ftea_pkg::RQ_PTR_W-1:0] rd_ptr_in;
   logic [ftea_pkg::RQ_PTR_W-1:0] cnt_in;
   logic                          accept;
   logic                          pop;

   // stage 0 decode
   logic                          s0_kind_ok;
   logic [OW-1:0]                 s0_off;
   logic [OW-1:0]                 s0_end;
   logic                          s0_fits;
   logic                          s0_in_last;
   logic                          s0_direct;
   logic [ftea_pkg::STATUS_W-1:0] s0_status;
   logic [VW-1:0]                 s0_raw;
   logic [VW-1:0]                 s0_mask;
   logic [ROW_W-1:0]              rd_row [LANES];
   logic [LANE_W-1:0]             s0_delta [LANES];
   logic [OW-1:0]                 s0_byte [LANES];

   // stage 1 registers
   logic                          s1_op_ff;
   logic                          s1_direct_ff;
   logic [ftea_pkg::STATUS_W-1:0] s1_status_ff;
   logic                          s1_odd_ff;
   logic [LANE_W-1:0]             s1_lo_ff;
   logic [VW-1:0]                 s1_wval_ff;
   logic [ROW_W-1:0]              s1_row_ff [LANES];
   logic                          fwd_hit_ff [LANES];
   logic [BW-1:0]                 fwd_data_ff [LANES];

   // stage 1 datapath
   logic [BW-1:0]                 ram_rdata [LANES];
   logic [BW-1:0]                 lane_byte [LANES];
   logic [BW-1:0]                 ent_byte [LANES];
   logic [BW-1:0]                 wr_ent [LANES];
   logic                          wr_ent_en [LANES];
   logic [BW-1:0]                 wr_data [LANES];
   logic                          wr_en [LANES];
   logic [LANES-1:0]              ram_we;
   logic [2*BW-1:0]               s1_v16;
   logic [VW-1:0]                 s1_entry;
   logic [VW-1:0]                 s1_emask;
   logic [VW-1:0]                 s1_eoc_pat;
   logic [VW-1:0]                 s1_bad_pat;
   ftea_pkg::result_type          s1_result;
   logic                          s1_writes;

   ftea_pkg::result_type          res_q_ff [ftea_pkg::RQ_DEPTH];

   assign req_chan.ready = !clear_ff &&
      ((3'(cnt_ff) + 3'(s1_valid_ff)) < 3'(ftea_pkg::RQ_DEPTH));
   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      s0_kind_ok = table_kind_ff inside {ftea_pkg::TK_FAT12, ftea_pkg::TK_FAT16,
                                         ftea_pkg::TK_FAT32};
      case (table_kind_ff)
         ftea_pkg::TK_FAT12: begin
            s0_off  = OW'(req_chan.cluster) + OW'(req_chan.cluster[CW-1:1]);
            s0_end  = s0_off + OW'(ftea_pkg::SPAN_SHORT);
            s0_mask = ftea_pkg::MASK12;
         end
         ftea_pkg::TK_FAT16: begin
            s0_off  = OW'({req_chan.cluster, 1'b0});
            s0_end  = s0_off + OW'(ftea_pkg::SPAN_SHORT);
            s0_mask = ftea_pkg::MASK16;
         end
         default: begin
            s0_off  = OW'({req_chan.cluster, 2'b00});
            s0_end  = s0_off + OW'(ftea_pkg::SPAN_LONG);
            s0_mask = ftea_pkg::MASK28;
         end
      endcase
      s0_fits    = 32'(s0_end) <= 32'(TABLE_BYTES);
      s0_in_last = req_chan.cluster <= last_cluster_ff;

      case (req_chan.next_kind)
         ftea_pkg::NK_EOC: s0_raw = ftea_pkg::EOC_MARK;
         ftea_pkg::NK_BAD: s0_raw = ftea_pkg::BAD_MARK;
         default:          s0_raw = req_chan.next_value;
      endcase

      if (req_chan.opcode == ftea_pkg::OP_READ) begin
         if (req_chan.cluster == CW'(1)) begin
            s0_direct = 1'b1;
            s0_status = ftea_pkg::ST_EOC;
         end else if (req_chan.cluster == '0 || !s0_in_last || !s0_kind_ok || !s0_fits) begin
            s0_direct = 1'b1;
            s0_status = ftea_pkg::ST_ERR;
         end else begin
            s0_direct = 1'b0;
            s0_status = ftea_pkg::ST_NEXT;
         end
      end else begin
         if (req_chan.cluster != CW'(1) && s0_in_last && s0_kind_ok &&
             req_chan.next_kind != ftea_pkg::NK_NONE && s0_fits) begin
            s0_direct = 1'b0;
            s0_status = ftea_pkg::ST_NEXT;
         end else begin
            s0_direct = 1'b1;
            s0_status = ftea_pkg::ST_ERR;
         end
      end

      for (int l = 0; l < LANES; l++) begin
         s0_delta[l] = LANE_W'(l) - s0_off[LANE_W-1:0];
         s0_byte[l]  = s0_off + OW'(s0_delta[l]);
         rd_row[l]   = ROW_W'(s0_byte[l][OW-1:LANE_W]);
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_byte[l] = fwd_hit_ff[l] ? fwd_data_ff[l] : ram_rdata[l];
      end
      for (int k = 0; k < LANES; k++) begin
         ent_byte[k] = lane_byte[LANE_W'(k) + s1_lo_ff];
      end
      s1_v16 = {ent_byte[1], ent_byte[0]};

      for (int k = 0; k < LANES; k++) begin
         wr_ent[k]    = '0;
         wr_ent_en[k] = 1'b0;
      end
      s1_writes = s1_valid_ff && s1_op_ff == ftea_pkg::OP_WRITE && !s1_direct_ff;

      case (table_kind_ff)
         ftea_pkg::TK_FAT12: begin
            s1_emask = ftea_pkg::MASK12;
            s1_entry = s1_odd_ff ? VW'(s1_v16[15:4]) : VW'(s1_v16[11:0]);
            if (s1_odd_ff) begin
               wr_ent[0] = (ent_byte[0] & ftea_pkg::NIB_LO) | {s1_wval_ff[3:0], 4'b0000};
               wr_ent[1] = s1_wval_ff[11:4];
            end else begin
               wr_ent[0] = s1_wval_ff[7:0];
               wr_ent[1] = (ent_byte[1] & ftea_pkg::NIB_HI) | {4'b0000, s1_wval_ff[11:8]};
            end
            wr_ent_en[0] = s1_writes;
            wr_ent_en[1] = s1_writes;
         end
         ftea_pkg::TK_FAT16: begin
            s1_emask     = ftea_pkg::MASK16;
            s1_entry     = VW'(s1_v16);
            wr_ent[0]    = s1_wval_ff[7:0];
            wr_ent[1]    = s1_wval_ff[15:8];
            wr_ent_en[0] = s1_writes;
            wr_ent_en[1] = s1_writes;
         end
         default: begin
            s1_emask  = ftea_pkg::MASK28;
            s1_entry  = VW'({ent_byte[3], ent_byte[2], ent_byte[1], ent_byte[0]});
            wr_ent[0] = s1_wval_ff[7:0];
            wr_ent[1] = s1_wval_ff[15:8];
            wr_ent[2] = s1_wval_ff[23:16];
            wr_ent[3] = {4'b0000, s1_wval_ff[27:24]};
            for (int k = 0; k < LANES; k++) begin
               wr_ent_en[k] = s1_writes;
            end
         end
      endcase

      for (int l = 0; l < LANES; l++) begin
         wr_data[l] = wr_ent[LANE_W'(l) - s1_lo_ff];
         wr_en[l]   = wr_ent_en[LANE_W'(l) - s1_lo_ff];
      end

      s1_eoc_pat = s1_emask & ftea_pkg::EOC_MARK;
      s1_bad_pat = s1_emask & ftea_pkg::BAD_MARK;
      s1_result.value = '0;
      if (s1_direct_ff || s1_op_ff == ftea_pkg::OP_WRITE) begin
         s1_result.status = s1_status_ff;
      end else if ((s1_entry & s1_eoc_pat) == s1_eoc_pat) begin
         s1_result.status = ftea_pkg::ST_EOC;
      end else if ((s1_entry & s1_bad_pat) == s1_bad_pat) begin
         s1_result.status = ftea_pkg::ST_BAD;
      end else if (s1_entry > VW'(last_cluster_ff)) begin
         s1_result.status = ftea_pkg::ST_ERR;
      end else if (s1_entry == '0) begin
         s1_result.status = ftea_pkg::ST_FREE;
      end else begin
         s1_result.status = ftea_pkg::ST_NEXT;
         s1_result.value  = s1_entry;
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [ROW_W-1:0] waddr;
      logic [BW-1:0]    wdata;

      assign ram_we[l] = clear_ff | wr_en[l];
      assign waddr     = clear_ff ? clear_row_ff : s1_row_ff[l];
      assign wdata     = clear_ff ? '0 : wr_data[l];

      ftea_ram #(
         .WIDTH (BW),
         .DEPTH (ROWS)
      ) u_ram (
         .clock (clock),
         .we    (ram_we[l]),
         .waddr (waddr),
         .wdata (wdata),
         .re    (accept),
         .raddr (rd_row[l]),
         .rdata (ram_rdata[l])
      );
   end

   // result queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (s1_valid_ff) begin
         wr_ptr_in = (wr_ptr_ff == ftea_pkg::RQ_PTR_W'(ftea_pkg::RQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ftea_pkg::RQ_PTR_W'(ftea_pkg::RQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + ftea_pkg::RQ_PTR_W'(s1_valid_ff) - ftea_pkg::RQ_PTR_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_row_ff <= '0;
         s1_valid_ff  <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
      end else begin
         if (clear_ff) begin
            clear_row_ff <= clear_row_ff + 1'b1;
            if (clear_row_ff == ROW_W'(ROWS - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         s1_valid_ff <= accept;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff     <= req_chan.opcode;
         s1_direct_ff <= s0_direct;
         s1_status_ff <= s0_status;
         s1_odd_ff    <= req_chan.cluster[0];
         s1_lo_ff     <= s0_off[LANE_W-1:0];
         s1_wval_ff   <= s0_raw & s0_mask;
         for (int l = 0; l < LANES; l++) begin
            s1_row_ff[l] <= rd_row[l];
         end
      end
      for (int l = 0; l < LANES; l++) begin
         fwd_hit_ff[l]  <= wr_en[l] && (s1_row_ff[l] == rd_row[l]);
         fwd_data_ff[l] <= wr_data[l];
      end
      if (s1_valid_ff) begin
         res_q_ff[wr_ptr_ff] <= s1_result;
      end
   end

   assign rsp_chan.valid  = cnt_ff != '0;
   assign rsp_chan.status = res_q_ff[rd_ptr_ff].status;
   assign rsp_chan.value  = res_q_ff[rd_ptr_ff].value;

   `ASSERT_ALWAYS(a_queue_bound, clock, reset,
      (3'(cnt_ff) + 3'(s1_valid_ff)) <= 3'(ftea_pkg::RQ_DEPTH), "result queue overrun")
   `ASSERT_NEXT(a_accept_stage, clock, reset, accept, s1_valid_ff, "accepted transaction lost")
   `ASSERT_ALWAYS(a_write_owner, clock, reset,
      !(|ram_we) || s1_valid_ff || clear_ff, "table write without transaction or clear")
   `ASSERT_ALWAYS(a_clear_quiet, clock, reset,
      !clear_ff || !s1_valid_ff, "transaction in flight during clear")

endmodule

`default_nettype wire

// ===== test/tb_fat_table_entry_access_unit.sv =====
`timescale 1ns / 100ps
// Testbench for fat_table_entry_access_unit: FAT12/16/32 entry reads and writes,
// checked against a byte-image model of the table kept alongside the run.
// Depends on ftea_pkg, ftea_if and the unit itself.

module tb_fat_table_entry_access_unit;
   import ftea_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam logic [TKIND_W-1:0] TK_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TABLE_KIND   = {REG_TABLE_KIND, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_LAST_CLUSTER = {REG_LAST_CLUSTER, 2'b00};
   localparam logic [CSR_DATA_W-1:0] TKIND_BITS   = CSR_DATA_W'((1 << TKIND_W) - 1);
   localparam logic [CSR_DATA_W-1:0] CLUSTER_BITS = CSR_DATA_W'((1 << CLUSTER_W) - 1);

   localparam logic [VALUE_W-1:0] ODD_LITERALS [8] = '{
      28'h0000FF7, 28'h0000FF8, 28'h000FFF7, 28'h000FFFF,
      28'hFFFFFF7, 28'hFFFFFF8, 28'h0000000, 28'h0003FFF
   };
   localparam logic [TKIND_W-1:0] LAYOUT_KINDS [9] = '{
      TK_FAT12, TK_FAT16, TK_FAT32, TK_FAT12, TK_FAT16,
      TK_FAT32, TK_FAT12, TK_FAT16, TK_UNUSED
   };
   localparam logic [CLUSTER_W-1:0] LAYOUT_LASTS [9] = '{
      14'd16383, 14'd16383, 14'd16383, 14'd2, 14'd700,
      14'd4095, 14'd3000, 14'd8191, 14'd5000
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   ftea_req_if req_chan();
   ftea_rsp_if rsp_chan();

   fat_table_entry_access_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [BYTE_W-1:0]    fat_image [TABLE_BYTES_DEF];
   logic [TKIND_W-1:0]   shadow_kind = TABLE_KIND_RST;
   logic [CLUSTER_W-1:0] shadow_last = LAST_CLUSTER_RST;
   result_type           access_results [$];
   logic                 gaps_on = 1'b1;
   int                   error_count = 0;
   int                   cycle_count = 0;
   int                   reads_sent = 0;
   int                   writes_sent = 0;
   int                   layouts_run = 1;
   int                   status_seen [5] = '{default: 0};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Watchdog expired after %0d cycles, %0d results outstanding",
                  cycle_count, access_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Apply one access to the table image and return the answer it should give.
   function automatic result_type table_access(input logic op, input logic [CLUSTER_W-1:0] cl,
                                               input logic [VALUE_W-1:0] nv,
                                               input logic [NKIND_W-1:0] nk);
      int unsigned entry_w;
      int unsigned span;
      int unsigned offs;
      logic        fits;
      logic [31:0] msk;
      logic [31:0] ent;
      logic [31:0] eoc;
      logic [31:0] bad;
      logic [31:0] wv;
      result_type  r;
      r.status = ST_ERR;
      r.value  = '0;
      case (shadow_kind)
         TK_FAT12: entry_w = 12;
         TK_FAT16: entry_w = 16;
         TK_FAT32: entry_w = 32;
         default:  entry_w = 0;
      endcase
      span = (entry_w == 32) ? SPAN_LONG : SPAN_SHORT;
      offs = (int'(cl) * entry_w) >> 3;
      fits = (entry_w != 0) && (offs + span <= TABLE_BYTES_DEF);
      msk  = (entry_w == 12) ? 32'(MASK12) : (entry_w == 16) ? 32'(MASK16) : 32'(MASK28);
      if (op == OP_READ) begin
         if (cl == 1) begin
            r.status = ST_EOC;
         end else if (cl == 0 || cl > shadow_last || !fits) begin
            r.status = ST_ERR;
         end else begin
            ent = {16'h0, fat_image[offs+1], fat_image[offs]};
            if (entry_w == 32) ent = ent | {fat_image[offs+3], fat_image[offs+2], 16'h0};
            if (entry_w == 12 && cl[0]) ent = ent >> 4;
            ent = ent & msk;
            eoc = msk & 32'(EOC_MARK);
            bad = msk & 32'(BAD_MARK);
            if ((ent & eoc) == eoc) r.status = ST_EOC;
            else if ((ent & bad) == bad) r.status = ST_BAD;
            else if (ent > 32'(shadow_last)) r.status = ST_ERR;
            else if (ent == 0) r.status = ST_FREE;
            else begin
               r.status = ST_NEXT;
               r.value  = VALUE_W'(ent);
            end
         end
      end else if (cl != 1 && cl <= shadow_last && fits && nk != NK_NONE) begin
         case (nk)
            NK_EOC:  wv = 32'(EOC_MARK);
            NK_BAD:  wv = 32'(BAD_MARK);
            default: wv = 32'(nv);
         endcase
         wv = wv & msk;
         if (entry_w == 12) begin
            // keep the neighbor's nibble in the shared byte
            if (!cl[0]) begin
               fat_image[offs]   = wv[7:0];
               fat_image[offs+1] = (fat_image[offs+1] & NIB_HI) | (wv[15:8] & NIB_LO);
            end else begin
               fat_image[offs]   = (fat_image[offs] & NIB_LO) | ({wv[3:0], 4'h0} & NIB_HI);
               fat_image[offs+1] = wv[11:4];
            end
         end else begin
            fat_image[offs]   = wv[7:0];
            fat_image[offs+1] = wv[15:8];
            if (entry_w == 32) begin
               fat_image[offs+2] = wv[23:16];
               fat_image[offs+3] = wv[31:24];
            end
         end
         r.status = ST_NEXT;
      end
      return r;
   endfunction

   initial begin : result_checker
      result_type want;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (rsp_chan.status < 5) status_seen[rsp_chan.status]++;
            if (access_results.size() == 0) begin
               $error("unexpected result transaction: status %0d value %h",
                      rsp_chan.status, rsp_chan.value);
               error_count++;
            end else begin
               want = access_results.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  error_count++;
               end
               if (rsp_chan.value !== want.value) begin
                  $error("value: expected %h, got %h", want.value, rsp_chan.value);
                  error_count++;
               end
            end
         end
         rsp_chan.ready <= !(gaps_on && $urandom_range(99) < 13);
      end
   end

   task automatic send_access(input logic op, input logic [CLUSTER_W-1:0] cl,
                              input logic [VALUE_W-1:0] nv, input logic [NKIND_W-1:0] nk);
      while (gaps_on && $urandom_range(99) < 13) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= op;
      req_chan.cluster    <= cl;
      req_chan.next_value <= nv;
      req_chan.next_kind  <= nk;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      access_results.push_back(table_access(op, cl, nv, nk));
      if (op == OP_READ) reads_sent++;
      else writes_sent++;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (access_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
   endtask

   task automatic csr_expect(input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] want,
                             input logic [CSR_DATA_W-1:0] bits, input string name);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if ((csr_prdata & bits) !== (want & bits)) begin
         $error("%s: expected %h, got %h", name, want & bits, csr_prdata & bits);
         error_count++;
      end
   endtask

   task automatic set_layout(input logic [TKIND_W-1:0] kind,
                             input logic [CLUSTER_W-1:0] last);
      settle();
      csr_write(ADDR_TABLE_KIND, CSR_DATA_W'(kind));
      csr_write(ADDR_LAST_CLUSTER, CSR_DATA_W'(last));
      csr_expect(ADDR_TABLE_KIND, CSR_DATA_W'(kind), TKIND_BITS, "table_kind");
      csr_expect(ADDR_LAST_CLUSTER, CSR_DATA_W'(last), CLUSTER_BITS, "last_cluster");
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      shadow_kind = kind;
      shadow_last = last;
      layouts_run++;
   endtask

   // Mostly chains written then walked, mixed with short bursts of arbitrary accesses.
   task automatic run_mixed_traffic(input int unsigned count);
      logic [CLUSTER_W-1:0] links [$];
      logic [CLUSTER_W-1:0] cl;
      logic [VALUE_W-1:0]   nv;
      logic [NKIND_W-1:0]   nk;
      int unsigned          lim;
      int unsigned          window;
      int unsigned          sent;
      int unsigned          len;
      case (shadow_kind)
         TK_FAT12: lim = (TABLE_BYTES_DEF - SPAN_SHORT) * 8 / 12;
         TK_FAT16: lim = (TABLE_BYTES_DEF - SPAN_SHORT) * 8 / 16;
         TK_FAT32: lim = (TABLE_BYTES_DEF - SPAN_LONG) * 8 / 32;
         default:  lim = shadow_last;
      endcase
      if (shadow_last < lim) lim = shadow_last;
      window = (lim < 65) ? lim : 65;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 6) begin
            links.delete();
            len = $urandom_range(8, 2);
            repeat (len)
               links.push_back(CLUSTER_W'($urandom_range(($urandom_range(4) == 0) ? lim : window,
                                                         2)));
            foreach (links[i]) begin
               if (i + 1 < links.size())
                  send_access(OP_WRITE, links[i], VALUE_W'(links[i+1]), NK_LITERAL);
               else
                  send_access(OP_WRITE, links[i], VALUE_W'($urandom),
                              ($urandom_range(3) == 0) ? NK_BAD : NK_EOC);
            end
            foreach (links[i])
               send_access(OP_READ, links[i], VALUE_W'($urandom), NKIND_W'($urandom_range(3)));
            sent += 2 * len;
         end else begin
            repeat ($urandom_range(8, 1)) begin
               case ($urandom_range(5))
                  0: cl = CLUSTER_W'($urandom);
                  1: begin
                     case ($urandom_range(3))
                        0:       cl = '0;
                        1:       cl = 14'd1;
                        2:       cl = CLUSTER_W'(lim);
                        default: cl = CLUSTER_W'((lim < 16383) ? lim + 1 : lim);
                     endcase
                  end
                  2: cl = CLUSTER_W'($urandom_range(lim));
                  default: cl = CLUSTER_W'($urandom_range(window));
               endcase
               case ($urandom_range(3))
                  0:       nv = VALUE_W'($urandom);
                  1:       nv = ODD_LITERALS[$urandom_range(7)];
                  default: nv = VALUE_W'($urandom_range(lim));
               endcase
               case ($urandom_range(9))
                  7:       nk = NK_EOC;
                  8:       nk = NK_BAD;
                  9:       nk = NK_NONE;
                  default: nk = NK_LITERAL;
               endcase
               send_access($urandom_range(1) ? OP_WRITE : OP_READ, cl, nv, nk);
               sent++;
            end
         end
      end
   endtask

   task automatic test_reset_values();
      csr_expect(ADDR_TABLE_KIND, CSR_DATA_W'(TABLE_KIND_RST), TKIND_BITS, "table_kind");
      csr_expect(ADDR_LAST_CLUSTER, CSR_DATA_W'(LAST_CLUSTER_RST), CLUSTER_BITS, "last_cluster");
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_cleared_table();
      send_access(OP_READ, 14'd0, '0, NK_LITERAL);
      send_access(OP_READ, 14'd1, '0, NK_LITERAL);
      send_access(OP_READ, 14'd2, '0, NK_LITERAL);
      send_access(OP_READ, 14'd16383, MASK28, NK_NONE);
   endtask

   task automatic test_fat12_entries();
      send_access(OP_WRITE, 14'd2, 28'h0000ABC, NK_LITERAL);
      send_access(OP_WRITE, 14'd3, 28'h0000123, NK_LITERAL);
      send_access(OP_READ, 14'd2, '0, NK_LITERAL);
      send_access(OP_READ, 14'd3, '0, NK_LITERAL);
      send_access(OP_WRITE, 14'd4, '0, NK_EOC);
      send_access(OP_WRITE, 14'd5, '0, NK_BAD);
      send_access(OP_READ, 14'd4, '0, NK_LITERAL);
      send_access(OP_READ, 14'd5, '0, NK_LITERAL);
      send_access(OP_WRITE, 14'd0, MASK28, NK_LITERAL);
      send_access(OP_WRITE, 14'd1, 28'd5, NK_LITERAL);
      send_access(OP_WRITE, 14'd6, 28'd7, NK_NONE);
      send_access(OP_WRITE, 14'd10921, BAD_MARK, NK_LITERAL);
      send_access(OP_WRITE, 14'd10922, 28'd3, NK_LITERAL);
      send_access(OP_READ, 14'd10921, '0, NK_LITERAL);
   endtask

   task automatic test_layout_extremes();
      set_layout(TK_FAT16, 14'd2);
      send_access(OP_WRITE, 14'd2, 28'd3, NK_LITERAL);
      send_access(OP_READ, 14'd2, '0, NK_LITERAL);
      send_access(OP_READ, 14'd3, '0, NK_LITERAL);
      set_layout(TK_FAT32, LAST_CLUSTER_RST);
      send_access(OP_WRITE, 14'd4095, MASK28, NK_LITERAL);
      send_access(OP_READ, 14'd4095, '0, NK_LITERAL);
      send_access(OP_WRITE, 14'd4096, 28'd9, NK_LITERAL);
      set_layout(TK_UNUSED, LAST_CLUSTER_RST);
      send_access(OP_READ, 14'd2, '0, NK_LITERAL);
      send_access(OP_WRITE, 14'd2, 28'd9, NK_LITERAL);
   endtask

   task automatic test_random_layouts();
      foreach (LAYOUT_KINDS[i]) begin
         set_layout(LAYOUT_KINDS[i], LAYOUT_LASTS[i]);
         run_mixed_traffic((LAYOUT_KINDS[i] == TK_UNUSED) ? 50 : 190);
      end
   endtask

   task automatic test_back_to_back();
      set_layout(TK_FAT12, LAST_CLUSTER_RST);
      gaps_on <= 1'b0;
      run_mixed_traffic(280);
      settle();
      gaps_on <= 1'b1;
   endtask

   task automatic finish_run();
      settle();
      repeat (10) @(posedge clock);
      $display("Checked %0d transactions (%0d reads, %0d writes) over %0d table layouts.",
               reads_sent + writes_sent, reads_sent, writes_sent, layouts_run);
      $display("Statuses seen: %0d next, %0d free, %0d end of chain, %0d bad, %0d error.",
               status_seen[ST_NEXT], status_seen[ST_FREE], status_seen[ST_EOC],
               status_seen[ST_BAD], status_seen[ST_ERR]);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   endtask

   initial begin
      foreach (fat_image[i]) fat_image[i] = '0;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.opcode     <= OP_READ;
      req_chan.cluster    <= '0;
      req_chan.next_value <= '0;
      req_chan.next_kind  <= NK_LITERAL;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_cleared_table();
      test_fat12_entries();
      test_layout_extremes();
      test_random_layouts();
      test_back_to_back();
      finish_run();
   end

endmodule
